// File: hw/rtl/xcbc_pkg.sv
// Shared types and constants for the chained XOR byte cipher.
// No dependencies; every other file of the block imports this package.
package xcbc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_KEY = 1'b1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [BYTE_W-1:0] FIXED_KEY_RESET = 8'hA9;

  typedef struct packed {
    logic              direction;
    logic [BYTE_W-1:0] fixed_key;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] random_key;
    logic              last_byte;
  } item_t;

endpackage

// File: hw/rtl/xcbc_cfg_regs.sv
// Configuration registers (direction, fixed key) of the chained XOR byte cipher.
// Depends on xcbc_pkg.
module xcbc_cfg_regs import xcbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction <= DIR_ENCODE;
      cfg.fixed_key <= FIXED_KEY_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIRECTION: cfg.direction <= cfg_data[0];
        REG_FIXED_KEY: cfg.fixed_key <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/xcbc_in_stage.sv
// Input register of the chained XOR byte cipher: holds one item until the
// transform stage takes it. Depends on xcbc_pkg.
module xcbc_in_stage import xcbc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  hold_valid,
  output item_t hold_item
);

  logic accept;

  assign in_stall = hold_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= in_item;
    end
  end

endmodule

// File: hw/rtl/xcbc_xform.sv
// Transform stage of the chained XOR byte cipher: chain state, the two XOR
// stages and the result register. Depends on xcbc_pkg.
module xcbc_xform import xcbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              hold_valid,
  input  item_t             hold_item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  logic [BYTE_W-1:0] byte_index;
  logic [BYTE_W-1:0] prev_middle;
  logic [BYTE_W-1:0] prev_encoded;
  logic [BYTE_W-1:0] idx_plus1;
  logic [BYTE_W-1:0] inner;
  logic [BYTE_W-1:0] outer;
  logic [BYTE_W-1:0] mid;
  logic [BYTE_W-1:0] res;
  logic [BYTE_W-1:0] enc;
  logic              advance;

  assign take    = !out_valid || !out_stall;
  assign advance = take && hold_valid;

  always_comb begin
    idx_plus1 = byte_index + 8'd1;
    inner     = hold_item.random_key + prev_middle + idx_plus1;
    outer     = cfg.fixed_key + idx_plus1 + prev_encoded;
    if (cfg.direction == DIR_DECODE) begin
      mid = hold_item.data_byte ^ outer;
      res = mid ^ inner;
      enc = hold_item.data_byte;
    end else begin
      mid = hold_item.data_byte ^ inner;
      res = mid ^ outer;
      enc = res;
    end
  end

  // Chain state: clear after a last byte, otherwise advance
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      prev_middle  <= '0;
      prev_encoded <= '0;
    end else if (advance) begin
      if (hold_item.last_byte) begin
        byte_index   <= '0;
        prev_middle  <= '0;
        prev_encoded <= '0;
      end else begin
        byte_index   <= idx_plus1;
        prev_middle  <= mid;
        prev_encoded <= enc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= res;
      out_last <= hold_item.last_byte;
    end
  end

endmodule

// File: hw/rtl/xor_chained_byte_cipher.sv
// Top level of the chained XOR byte cipher.
// Depends on xcbc_pkg, xcbc_cfg_regs, xcbc_in_stage and xcbc_xform.
//
// Obfuscates or restores packet payload one byte per item. Each byte passes
// two XOR stages chained to the previous byte of the packet:
//   mid = data ^ (random_key + prev_mid + i + 1)
//   out = mid  ^ (fixed_key  + i + 1 + prev_encoded)
// with all sums mod 256 and i the byte position in the packet. Decoding
// applies the stages in reverse order. The chain and the index return to zero
// after an item flagged last_byte, so each packet starts fresh; an index past
// 255 wraps. The block takes one item per cycle unless the output stalls,
// and each result passes the input register, then the result register; the
// 8-bit chain update is registered with the result, so back-to-back
// bytes of a packet never wait on one another. A stalled output holds the
// result register, and one more item waits in the input register before
// in_stall rises. Configuration: index 0 is direction (bit 0: 0 encode,
// 1 decode, reset encode), index 1 is fixed_key (reset 0xA9). Write them only
// while no item is in flight; a change takes effect from the next item on.
module xor_chained_byte_cipher import xcbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic [BYTE_W-1:0]    random_key,
  input  logic                 last_byte,
  // result item channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_last
);

  cfg_t  cfg;
  item_t in_item;
  item_t hold_item;
  logic  hold_valid;
  logic  take;

  // Bundle the payload ports into one item
  assign in_item = '{data_byte: data_byte, random_key: random_key, last_byte: last_byte};

  xcbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Hold the accepted item until the transform stage has room
  xcbc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Apply both XOR stages, advance the chain and register the result
  xcbc_xform u_xform (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

// File: test/xor_chained_byte_cipher_test.sv
// Self-checking testbench for the chained XOR byte cipher, encode and decode.
// Needs xcbc_pkg and the xor_chained_byte_cipher RTL; holds its own cipher
// predictor and checks every result item against it in order.
module xor_chained_byte_cipher_test import xcbc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // One expected result item: the transformed byte and the packet-end flag.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } cipher_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] random_key;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  // Predictor copy of the registers and of the per-packet chain.
  logic              cfg_dir;
  logic [BYTE_W-1:0] cfg_key;
  logic [BYTE_W-1:0] byte_pos;
  logic [BYTE_W-1:0] chain_mid;
  logic [BYTE_W-1:0] chain_enc;

  cipher_result_t    pending_results[$];

  int unsigned       errors;
  int unsigned       bytes_sent;
  int unsigned       packets_sent;
  int unsigned       results_checked;
  int unsigned       input_stall_cycles;
  int unsigned       decode_bytes;

  // Traffic shaping shared with the idle processes.
  bit                tx_calm;
  bit                rx_calm;
  int unsigned       hold_off;
  int unsigned       rx_stall_left;

  xor_chained_byte_cipher dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .random_key (random_key),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the simulated run time; hitting it reports a mismatch.
  initial begin
    #10_000_000;
    $display("xor_chained_byte_cipher: mismatch");
    $finish;
  end

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advance the cipher predictor by one accepted item and queue its result.
  function void predict_cipher_byte(item_t it);
    logic [BYTE_W-1:0] inner_pad;
    logic [BYTE_W-1:0] outer_pad;
    logic [BYTE_W-1:0] mid;
    logic [BYTE_W-1:0] res;
    logic [BYTE_W-1:0] enc;
    cipher_result_t    r;
    inner_pad = it.random_key + chain_mid + byte_pos + 8'd1;
    outer_pad = cfg_key + byte_pos + 8'd1 + chain_enc;
    if (cfg_dir == DIR_ENCODE) begin
      mid = it.data_byte ^ inner_pad;
      res = mid ^ outer_pad;
      enc = res;
    end else begin
      // decode peels the outer stage first; the chain follows the input byte
      mid = it.data_byte ^ outer_pad;
      res = mid ^ inner_pad;
      enc = it.data_byte;
      decode_bytes++;
    end
    r.out_byte = res;
    r.out_last = it.last_byte;
    pending_results.push_back(r);
    if (it.last_byte) begin
      byte_pos  = '0;
      chain_mid = '0;
      chain_enc = '0;
      packets_sent++;
    end else begin
      byte_pos  = byte_pos + 8'd1;
      chain_mid = mid;
      chain_enc = enc;
    end
  endfunction

  task automatic report_error(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
    $display("ERROR at %0t: %s got %02h want %02h", $time, what, got, want);
    errors++;
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic send_byte(logic [BYTE_W-1:0] d, logic [BYTE_W-1:0] k, logic l);
    int unsigned gap;
    item_t       it;
    gap = tx_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    data_byte  <= d;
    random_key <= k;
    last_byte  <= l;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    it.data_byte  = d;
    it.random_key = k;
    it.last_byte  = l;
    predict_cipher_byte(it);
    bytes_sent++;
  endtask

  // Drop valid, wait until every queued result has come back, then let the
  // pipeline settle.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers are only written with the pipeline empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
    drain_pipeline();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_DIRECTION) cfg_dir = value[0];
    else                      cfg_key = value;
  endtask

  // One packet: well-formed packets keep one random key, noisy ones change it
  // on every byte.
  task automatic send_packet(int unsigned len, bit noisy);
    logic [BYTE_W-1:0] key;
    int unsigned       i;
    key = BYTE_W'($urandom());
    for (i = 0; i < len; i++) begin
      if (noisy) key = BYTE_W'($urandom());
      send_byte(BYTE_W'($urandom()), key, i == len - 1);
    end
  endtask

  // --- tests ---------------------------------------------------------------

  // Encode with the reset register values, no writes yet.
  task automatic test_reset_defaults();
    send_byte(8'h00, 8'h00, 1'b0);
    send_byte(8'hFF, 8'hFF, 1'b0);
    send_byte(8'h55, 8'hAA, 1'b0);
    send_byte(8'hAA, 8'h55, 1'b1);
  endtask

  // Extreme field values under both directions and both key extremes.
  task automatic test_field_extremes();
    int unsigned dir;
    int unsigned kx;
    for (dir = 0; dir < 2; dir++) begin
      for (kx = 0; kx < 2; kx++) begin
        write_reg(REG_DIRECTION, BYTE_W'(dir ? DIR_DECODE : DIR_ENCODE));
        write_reg(REG_FIXED_KEY, kx ? 8'hFF : 8'h00);
        send_byte(8'hFF, 8'h00, 1'b0);
        send_byte(8'h00, 8'hFF, 1'b1);
      end
    end
  endtask

  // Change direction and then the fixed key in the middle of one packet;
  // the chain carries on untouched.
  task automatic test_mid_packet_changes();
    write_reg(REG_DIRECTION, BYTE_W'(DIR_ENCODE));
    write_reg(REG_FIXED_KEY, 8'h3C);
    send_byte(8'h12, 8'h77, 1'b0);
    send_byte(8'h34, 8'h77, 1'b0);
    send_byte(8'h56, 8'h77, 1'b0);
    write_reg(REG_DIRECTION, BYTE_W'(DIR_DECODE));
    send_byte(8'h9A, 8'h77, 1'b0);
    send_byte(8'hBC, 8'h01, 1'b0);
    write_reg(REG_FIXED_KEY, 8'hC3);
    send_byte(8'hDE, 8'hFE, 1'b0);
    send_byte(8'hF0, 8'h80, 1'b1);
  endtask

  // Packets longer than 256 bytes so the position wraps, in both directions.
  task automatic test_index_wrap();
    write_reg(REG_DIRECTION, BYTE_W'(DIR_ENCODE));
    write_reg(REG_FIXED_KEY, BYTE_W'($urandom()));
    send_packet(290, 1'b0);
    write_reg(REG_DIRECTION, BYTE_W'(DIR_DECODE));
    send_packet(300, 1'b0);
  endtask

  // Hold the output off long enough for the block to back up and stall its
  // input while items keep coming back to back.
  task automatic test_backpressure();
    tx_calm  = 1'b1;
    hold_off = 80;
    send_packet(40, 1'b0);
    tx_calm  = 1'b0;
    drain_pipeline();
  endtask

  // Random packets across several register settings; one phase runs with no
  // idling on either side.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned phase_bytes;
    int unsigned len;
    int unsigned roll;
    logic        dir;
    logic [BYTE_W-1:0] key;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin dir = DIR_ENCODE; key = BYTE_W'($urandom()); end
        1: begin dir = DIR_DECODE; key = BYTE_W'($urandom()); end
        2: begin dir = DIR_ENCODE; key = 8'h00; end
        3: begin dir = DIR_DECODE; key = 8'hFF; end
        4: begin dir = 1'($urandom_range(0, 1)); key = BYTE_W'($urandom()); end
        default: begin dir = DIR_DECODE; key = FIXED_KEY_RESET; end
      endcase
      write_reg(REG_DIRECTION, BYTE_W'(dir));
      write_reg(REG_FIXED_KEY, key);
      tx_calm = (phase == 2);
      rx_calm = (phase == 2);
      phase_bytes = 0;
      while (phase_bytes < 230) begin
        roll = $urandom_range(0, 99);
        len  = (roll < 75) ? $urandom_range(1, 16) : $urandom_range(17, 64);
        send_packet(len, $urandom_range(0, 99) < 15);
        phase_bytes += len;
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
    end
  endtask

  // --- receiver idling -------------------------------------------------------

  // Random output stalls, plus the long hold-off counted down here.
  initial begin
    out_stall     = 1'b0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
      end else if (rx_stall_left > 0) begin
        out_stall <= 1'b1;
        rx_stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
      end
    end
  end

  // --- result checking -------------------------------------------------------

  // Compare every accepted result item with the oldest expectation.
  always @(posedge clk) begin
    cipher_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_error("unexpected result, out_byte", out_byte, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.out_byte) report_error("out_byte", out_byte, want.out_byte);
        if (out_last !== want.out_last)
          report_error("out_last", BYTE_W'(out_last), BYTE_W'(want.out_last));
        results_checked++;
      end
    end
  end

  // --- sequence --------------------------------------------------------------

  initial begin
    rst        = 1'b1;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_DIRECTION;
    cfg_data   = '0;
    in_valid   = 1'b0;
    data_byte  = '0;
    random_key = '0;
    last_byte  = 1'b0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hold_off   = 0;
    errors     = 0;
    bytes_sent = 0;
    packets_sent       = 0;
    results_checked    = 0;
    input_stall_cycles = 0;
    decode_bytes       = 0;
    cfg_dir   = DIR_ENCODE;
    cfg_key   = FIXED_KEY_RESET;
    byte_pos  = '0;
    chain_mid = '0;
    chain_enc = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_mid_packet_changes();
    test_backpressure();
    test_index_wrap();
    test_random_traffic();
    drain_pipeline();
    repeat (10) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("ERROR: %0d results never arrived", pending_results.size());
      errors++;
    end
    $display("Covered %0d bytes in %0d packets (%0d decoded), %0d results checked,",
             bytes_sent, packets_sent, decode_bytes, results_checked);
    $display("position wrap, mid-packet register changes, input stalled %0d cycles.",
             input_stall_cycles);
    if (errors == 0) begin
      $display("xor_chained_byte_cipher: match");
    end else begin
      $display("xor_chained_byte_cipher: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/xcbc_pkg.sv
hw/rtl/xcbc_cfg_regs.sv
hw/rtl/xcbc_in_stage.sv
hw/rtl/xcbc_xform.sv
hw/rtl/xor_chained_byte_cipher.sv
test/xor_chained_byte_cipher_test.sv
